/* rtl/line_position_pd_steering_defines.svh */
// Assertion macros shared by the steering block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef LINE_POSITION_PD_STEERING_DEFINES_SVH
`define LINE_POSITION_PD_STEERING_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPPS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LPPS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lpps_pkg.sv */
package lpps_pkg;

    localparam int SENSOR_COUNT   = 7;
    localparam int SAMPLE_BITS    = 12;
    localparam int STOP_BITS      = 12;
    localparam int GAIN_BITS      = 24;
    localparam int SPEED_BITS     = 16;
    localparam int ERR_BITS       = 11;
    localparam int DIFF_BITS      = ERR_BITS + 1;
    localparam int FRAC_BITS      = 8;
    localparam int COUNT_BITS     = 3;
    localparam int WSUM_BITS      = 5;
    localparam int THR_A_BITS     = 48;
    localparam int THR_B_BITS     = 36;
    localparam int THR_BITS       = THR_A_BITS + THR_B_BITS;

    // Serial divider: one quotient bit per step.
    localparam int DIV_STEPS      = WSUM_BITS + FRAC_BITS;
    localparam int DIV_CNT_BITS   = $clog2(DIV_STEPS + 1);
    localparam int QUOT_BITS      = ERR_BITS;

    // Serial multiplier: one multiplier bit of error and of difference per step.
    localparam int MULT_STEPS     = DIFF_BITS;
    localparam int MULT_CNT_BITS  = $clog2(MULT_STEPS + 1);
    localparam int ACC_BITS       = GAIN_BITS + DIFF_BITS + 2;
    localparam int PROD_SHIFT     = 16;
    localparam int MAG_BITS       = ACC_BITS - PROD_SHIFT;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 48;

    localparam logic [CFG_INDEX_BITS-1:0] REG_THR_A      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_THR_B      = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_KP         = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_KD         = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_SPEED = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STOP_LEVEL = 3'd5;

    localparam logic [STOP_BITS-1:0]        STOP_LEVEL_RESET = 12'd2500;
    localparam logic signed [ERR_BITS:0]    CENTER_Q         = 12'sd1024;
    localparam logic signed [ERR_BITS-1:0]  ONE_Q            = 11'sd256;
    localparam logic [SPEED_BITS-1:0]       SPEED_MAX        = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_ERR,
        ST_MULT_START,
        ST_MULT_WAIT,
        ST_MAG,
        ST_SPEED
    } lpps_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } lpps_unit_stat_t;

endpackage

/* rtl/lpps_sample_if.sv */
interface lpps_sample_if;
    logic                             valid;
    logic                             ready;
    logic [lpps_pkg::SAMPLE_BITS-1:0] sensor_0;
    logic [lpps_pkg::SAMPLE_BITS-1:0] sensor_1;
    logic [lpps_pkg::SAMPLE_BITS-1:0] sensor_2;
    logic [lpps_pkg::SAMPLE_BITS-1:0] sensor_3;
    logic [lpps_pkg::SAMPLE_BITS-1:0] sensor_4;
    logic [lpps_pkg::SAMPLE_BITS-1:0] sensor_5;
    logic [lpps_pkg::SAMPLE_BITS-1:0] sensor_6;
    logic [lpps_pkg::STOP_BITS-1:0]   stop_sensor;

    modport source (
        output valid, sensor_0, sensor_1, sensor_2, sensor_3, sensor_4, sensor_5, sensor_6,
        output stop_sensor,
        input  ready
    );
    modport sink (
        input  valid, sensor_0, sensor_1, sensor_2, sensor_3, sensor_4, sensor_5, sensor_6,
        input  stop_sensor,
        output ready
    );
endinterface

/* rtl/lpps_result_if.sv */
interface lpps_result_if;
    logic                                  valid;
    logic                                  ready;
    logic [lpps_pkg::SPEED_BITS-1:0]       left_speed;
    logic [lpps_pkg::SPEED_BITS-1:0]       right_speed;
    logic [lpps_pkg::SENSOR_COUNT-1:0]     line_bits;
    logic signed [lpps_pkg::ERR_BITS-1:0]  position_error;
    logic                                  stop;

    modport source (
        output valid, left_speed, right_speed, line_bits, position_error, stop,
        input  ready
    );
    modport sink (
        input  valid, left_speed, right_speed, line_bits, position_error, stop,
        output ready
    );
endinterface

/* rtl/lpps_cfg_if.sv */
interface lpps_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [lpps_pkg::CFG_INDEX_BITS-1:0] index;
    logic [lpps_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/lpps_divider.sv */
// Restoring divider, one quotient bit per cycle, for the weighted sensor mean.
module lpps_divider (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [lpps_pkg::WSUM_BITS-1:0]     dividend,
    input  logic [lpps_pkg::COUNT_BITS-1:0]    divisor,
    output logic [lpps_pkg::QUOT_BITS-1:0]     quotient,
    output lpps_pkg::lpps_unit_stat_t          stat
);
    localparam int STEPS    = lpps_pkg::DIV_STEPS;
    localparam int CNT_BITS = lpps_pkg::DIV_CNT_BITS;
    localparam int DEN_BITS = lpps_pkg::COUNT_BITS;
    localparam int FRAC     = lpps_pkg::FRAC_BITS;

    logic [STEPS-1:0]    num_reg, num_next;
    logic [STEPS-1:0]    quot_reg, quot_next;
    logic [DEN_BITS-1:0] rem_reg, rem_next;
    logic [DEN_BITS-1:0] den_reg, den_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS:0]   trial_sub;
    logic                fits;

    always_comb
    begin
        trial     = {rem_reg, num_reg[STEPS-1]};
        trial_sub = trial - {1'b0, den_reg};
        fits      = (trial >= {1'b0, den_reg});
    end

    always_comb
    begin
        num_next  = num_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            num_next  = {dividend, {FRAC{1'b0}}};
            quot_next = '0;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = CNT_BITS'(STEPS);
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            num_next  = {num_reg[STEPS-2:0], 1'b0};
            quot_next = {quot_reg[STEPS-2:0], fits};
            rem_next  = fits ? trial_sub[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign quotient  = quot_reg[lpps_pkg::QUOT_BITS-1:0];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* rtl/lpps_pd_mult.sv */
// Shift-and-add PD product. Error and error difference are scanned one bit per
// cycle, sign bit first, and both gains are added into one accumulator.
module lpps_pd_mult (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [lpps_pkg::GAIN_BITS-1:0]       kp,
    input  logic [lpps_pkg::GAIN_BITS-1:0]       kd,
    input  logic signed [lpps_pkg::ERR_BITS-1:0] err,
    input  logic signed [lpps_pkg::DIFF_BITS-1:0] diff,
    output logic signed [lpps_pkg::ACC_BITS-1:0] product,
    output lpps_pkg::lpps_unit_stat_t            stat
);
    localparam int STEPS    = lpps_pkg::MULT_STEPS;
    localparam int CNT_BITS = lpps_pkg::MULT_CNT_BITS;
    localparam int GAIN     = lpps_pkg::GAIN_BITS;
    localparam int ACC      = lpps_pkg::ACC_BITS;

    logic [STEPS-1:0]      e_sr_reg, e_sr_next;
    logic [STEPS-1:0]      d_sr_reg, d_sr_next;
    logic signed [ACC-1:0] acc_reg, acc_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [GAIN-1:0]       kp_sel;
    logic [GAIN-1:0]       kd_sel;
    logic [GAIN:0]         term;
    logic signed [ACC-1:0] term_ext;
    logic signed [ACC-1:0] acc_shift;
    logic                  sign_step;

    always_comb
    begin
        kp_sel    = e_sr_reg[STEPS-1] ? kp : '0;
        kd_sel    = d_sr_reg[STEPS-1] ? kd : '0;
        term      = {1'b0, kp_sel} + {1'b0, kd_sel};
        term_ext  = signed'({{(ACC-GAIN-1){1'b0}}, term});
        acc_shift = {acc_reg[ACC-2:0], 1'b0};
        // The first bit scanned is the two's complement sign bit, worth minus its weight.
        sign_step = (cnt_reg == CNT_BITS'(STEPS));
    end

    always_comb
    begin
        e_sr_next = e_sr_reg;
        d_sr_next = d_sr_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            e_sr_next = {err[lpps_pkg::ERR_BITS-1], err};
            d_sr_next = diff;
            acc_next  = '0;
            cnt_next  = CNT_BITS'(STEPS);
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            e_sr_next = {e_sr_reg[STEPS-2:0], 1'b0};
            d_sr_next = {d_sr_reg[STEPS-2:0], 1'b0};
            acc_next  = sign_step ? (acc_shift - term_ext) : (acc_shift + term_ext);
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_sr_reg <= e_sr_next;
        d_sr_reg <= d_sr_next;
        acc_reg  <= acc_next;
    end

    assign product   = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* rtl/line_position_pd_steering.sv */
// Line-position PD steering controller.
// The sample channel carries one sensor scan per beat: seven line samples and
// a stop-sensor sample. The result channel returns one beat per scan with both
// wheel speeds, the line pattern, the new line error and the stop flag.
// The configuration channel writes thresholds, gains, base speed and stop level
// by register index; it is always ready and must be written only while idle.
// A scan is accepted only while idle, so the next scan waits until the current
// one is through. The scan time is set by the serial divider (13 steps, one
// quotient bit each) that forms the mean line position and the serial
// multiplier (12 steps, one error bit each) that forms the PD term, plus the
// sequencing states.
// Reset clears the line error, the gains, thresholds and base speed, and sets
// the stop level to 2500. A finished result waits in an output register; the
// next scan can be accepted and worked on meanwhile, and the block holds its
// new result until the receiver takes the previous one.
`include "line_position_pd_steering_defines.svh"

module line_position_pd_steering (
    input  logic          clk,
    input  logic          rst_n,
    lpps_sample_if.sink   sample,
    lpps_result_if.source result,
    lpps_cfg_if.sink      cfg
);
    localparam int NSENS     = lpps_pkg::SENSOR_COUNT;
    localparam int SBITS     = lpps_pkg::SAMPLE_BITS;
    localparam int CBITS     = lpps_pkg::COUNT_BITS;
    localparam int WBITS     = lpps_pkg::WSUM_BITS;
    localparam int EBITS     = lpps_pkg::ERR_BITS;
    localparam int DBITS     = lpps_pkg::DIFF_BITS;
    localparam int ABITS     = lpps_pkg::ACC_BITS;
    localparam int MBITS     = lpps_pkg::MAG_BITS;
    localparam int VBITS     = lpps_pkg::SPEED_BITS;
    localparam int HBITS     = MBITS + 1;

    // Configuration registers.
    logic [lpps_pkg::THR_A_BITS-1:0] thr_a_reg;
    logic [lpps_pkg::THR_B_BITS-1:0] thr_b_reg;
    logic [lpps_pkg::GAIN_BITS-1:0]  kp_reg;
    logic [lpps_pkg::GAIN_BITS-1:0]  kd_reg;
    logic [VBITS-1:0]                base_reg;
    logic [lpps_pkg::STOP_BITS-1:0]  stop_level_reg;

    // Sequencer and per-scan state.
    lpps_pkg::lpps_state_t state_reg, state_next;
    logic [NSENS-1:0]        bits_reg;
    logic                    stop_reg;
    logic [CBITS-1:0]        count_reg;
    logic [WBITS-1:0]        wsum_reg;
    logic signed [EBITS-1:0] err_reg;
    logic signed [DBITS-1:0] diff_reg;
    logic signed [EBITS-1:0] line_error_reg;
    logic [MBITS-1:0]        mag_reg;

    // Output register.
    logic                    out_valid_reg;
    logic [VBITS-1:0]        left_reg;
    logic [VBITS-1:0]        right_reg;
    logic [NSENS-1:0]        line_bits_reg;
    logic signed [EBITS-1:0] pos_err_reg;
    logic                    stop_out_reg;

    // Sequencer outputs.
    logic in_ready;
    logic div_start;
    logic mult_start;
    logic load;
    logic accept;

    logic [SBITS-1:0]              samples [NSENS];
    logic [lpps_pkg::THR_BITS-1:0] thr_all;
    logic [NSENS-1:0]              bits_in;
    logic [CBITS-1:0]              count_in;
    logic [WBITS-1:0]              wsum_in;
    logic                          stop_in;

    logic [lpps_pkg::QUOT_BITS-1:0] quotient;
    lpps_pkg::lpps_unit_stat_t      div_stat;
    logic signed [ABITS-1:0]        product;
    lpps_pkg::lpps_unit_stat_t      mult_stat;

    logic signed [EBITS:0]   mean_err;
    logic signed [EBITS-1:0] err_new;
    logic signed [DBITS-1:0] diff_new;
    logic [ABITS-1:0]        prod_abs;
    logic [HBITS-1:0]        high_sum;
    logic [VBITS-1:0]        high_speed;
    logic [VBITS-1:0]        low_speed;
    logic [VBITS-1:0]        left_next;
    logic [VBITS-1:0]        right_next;

    // ------------------------------------------------------------------
    // Configuration writes. The channel never stalls.
    // ------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_a_reg      <= '0;
            thr_b_reg      <= '0;
            kp_reg         <= '0;
            kd_reg         <= '0;
            base_reg       <= '0;
            stop_level_reg <= lpps_pkg::STOP_LEVEL_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                lpps_pkg::REG_THR_A:      thr_a_reg      <= cfg.data[lpps_pkg::THR_A_BITS-1:0];
                lpps_pkg::REG_THR_B:      thr_b_reg      <= cfg.data[lpps_pkg::THR_B_BITS-1:0];
                lpps_pkg::REG_KP:         kp_reg         <= cfg.data[lpps_pkg::GAIN_BITS-1:0];
                lpps_pkg::REG_KD:         kd_reg         <= cfg.data[lpps_pkg::GAIN_BITS-1:0];
                lpps_pkg::REG_BASE_SPEED: base_reg       <= cfg.data[VBITS-1:0];
                lpps_pkg::REG_STOP_LEVEL: stop_level_reg <= cfg.data[lpps_pkg::STOP_BITS-1:0];
                default:                  ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Threshold compare, sensor count and weighted position sum of a scan.
    // Sensor i carries position weight i+1.
    // ------------------------------------------------------------------
    assign samples[0] = sample.sensor_0;
    assign samples[1] = sample.sensor_1;
    assign samples[2] = sample.sensor_2;
    assign samples[3] = sample.sensor_3;
    assign samples[4] = sample.sensor_4;
    assign samples[5] = sample.sensor_5;
    assign samples[6] = sample.sensor_6;
    assign thr_all    = {thr_b_reg, thr_a_reg};

    always_comb
    begin
        bits_in  = '0;
        count_in = '0;
        wsum_in  = '0;
        for (int i = 0; i < NSENS; i++)
        begin
            bits_in[i] = (samples[i] >= thr_all[i*SBITS +: SBITS]);
            count_in   = count_in + CBITS'(bits_in[i]);
            wsum_in    = wsum_in + (bits_in[i] ? WBITS'(i + 1) : WBITS'(0));
        end
        stop_in = (sample.stop_sensor < stop_level_reg);
    end

    assign accept = sample.valid && sample.ready;

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lpps_pkg::ST_IDLE:       if (sample.valid) state_next = lpps_pkg::ST_DIV_START;
            lpps_pkg::ST_DIV_START:  state_next = lpps_pkg::ST_DIV_WAIT;
            lpps_pkg::ST_DIV_WAIT:   if (div_stat.done) state_next = lpps_pkg::ST_ERR;
            lpps_pkg::ST_ERR:        state_next = lpps_pkg::ST_MULT_START;
            lpps_pkg::ST_MULT_START: state_next = lpps_pkg::ST_MULT_WAIT;
            lpps_pkg::ST_MULT_WAIT:  if (mult_stat.done) state_next = lpps_pkg::ST_MAG;
            lpps_pkg::ST_MAG:        state_next = lpps_pkg::ST_SPEED;
            lpps_pkg::ST_SPEED:      if (!out_valid_reg || result.ready) state_next = lpps_pkg::ST_IDLE;
            default:                 state_next = lpps_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs.
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ready   = 1'b0;
        div_start  = 1'b0;
        mult_start = 1'b0;
        load       = 1'b0;
        case (state_reg)
            lpps_pkg::ST_IDLE:       in_ready   = 1'b1;
            lpps_pkg::ST_DIV_START:  div_start  = 1'b1;
            lpps_pkg::ST_MULT_START: mult_start = 1'b1;
            lpps_pkg::ST_SPEED:      load       = !out_valid_reg || result.ready;
            default:                 ;
        endcase
    end

    assign sample.ready = in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lpps_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Mean position: weighted sum times 256 over the sensor count.
    // A zero count still runs the divider, but its quotient is not used.
    // ------------------------------------------------------------------
    lpps_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (wsum_reg),
        .divisor  (count_reg),
        .quotient (quotient),
        .stat     (div_stat)
    );

    // New line error. An empty pattern keeps a large error so the robot keeps
    // turning toward where the line was last seen; a full pattern centers it.
    always_comb
    begin
        mean_err = signed'({1'b0, quotient}) - lpps_pkg::CENTER_Q;
        if (count_reg == '0)
        begin
            if (line_error_reg >= lpps_pkg::ONE_Q || line_error_reg <= -lpps_pkg::ONE_Q)
            begin
                err_new = line_error_reg;
            end
            else
            begin
                err_new = '0;
            end
        end
        else if (count_reg == CBITS'(NSENS))
        begin
            err_new = '0;
        end
        else
        begin
            err_new = mean_err[EBITS-1:0];
        end
        diff_new = {err_new[EBITS-1], err_new} - {line_error_reg[EBITS-1], line_error_reg};
    end

    // ------------------------------------------------------------------
    // PD term: kp * error + kd * (error - previous error), Q.16.
    // ------------------------------------------------------------------
    lpps_pd_mult u_pd_mult (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mult_start),
        .kp      (kp_reg),
        .kd      (kd_reg),
        .err     (err_reg),
        .diff    (diff_reg),
        .product (product),
        .stat    (mult_stat)
    );

    // Magnitude truncates toward zero, then the wheel speeds saturate.
    always_comb
    begin
        prod_abs   = product[ABITS-1] ? ABITS'(-product) : ABITS'(product);
        high_sum   = {{(HBITS-VBITS){1'b0}}, base_reg} + {1'b0, mag_reg};
        high_speed = (high_sum > HBITS'(lpps_pkg::SPEED_MAX)) ? lpps_pkg::SPEED_MAX
                                                             : high_sum[VBITS-1:0];
        low_speed  = (mag_reg >= MBITS'(base_reg)) ? '0 : (base_reg - mag_reg[VBITS-1:0]);
        if (err_reg[EBITS-1])
        begin
            left_next  = low_speed;
            right_next = high_speed;
        end
        else
        begin
            left_next  = high_speed;
            right_next = low_speed;
        end
        if (stop_reg)
        begin
            left_next  = '0;
            right_next = '0;
        end
    end

    // ------------------------------------------------------------------
    // Per-scan datapath registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bits_reg  <= bits_in;
            count_reg <= count_in;
            wsum_reg  <= wsum_in;
            stop_reg  <= stop_in;
        end
        if (state_reg == lpps_pkg::ST_ERR)
        begin
            err_reg  <= err_new;
            diff_reg <= diff_new;
        end
        if (state_reg == lpps_pkg::ST_MAG)
        begin
            mag_reg <= prod_abs[ABITS-1:lpps_pkg::PROD_SHIFT];
        end
        if (load)
        begin
            left_reg      <= left_next;
            right_reg     <= right_next;
            line_bits_reg <= bits_reg;
            pos_err_reg   <= err_reg;
            stop_out_reg  <= stop_reg;
        end
    end

    // The line error is also the previous error of the next scan.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_error_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                line_error_reg <= err_reg;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.left_speed     = left_reg;
    assign result.right_speed    = right_reg;
    assign result.line_bits      = line_bits_reg;
    assign result.position_error = pos_err_reg;
    assign result.stop           = stop_out_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `LPPS_ASSERT_IMP(a_stop_zero_speed, result.valid && result.stop,
        result.left_speed == '0 && result.right_speed == '0, "speed reported while stopped")
    `LPPS_ASSERT_IMP(a_err_in_range, state_reg == lpps_pkg::ST_MULT_START,
        err_reg <= 11'sd768 && err_reg >= -11'sd768, "line error out of range")
    `LPPS_ASSERT_NXT(a_accept_starts_div, accept,
        state_reg == lpps_pkg::ST_DIV_START && !sample.ready, "scan accepted without divide")
    `LPPS_ASSERT_NXT(a_load_shows_result, load,
        result.valid && state_reg == lpps_pkg::ST_IDLE, "loaded result not presented")

endmodule
